[rtl/nnsr_pkg.sv]
// Shared constants, codes and types of the nearest-neighbor sample ring.
package nnsr_pkg;

  // Ring geometry and field widths.
  localparam int MAX_DIM   = 8;
  localparam int DIM_W     = 3;
  localparam int DEPTH     = 256;
  localparam int ENT_W     = 8;
  localparam int SMP_DEPTH = DEPTH * MAX_DIM;
  localparam int SMP_AW    = ENT_W + DIM_W;
  localparam int VAL_W     = 16;
  localparam int DIF_W     = 17;
  localparam int SQ_W      = 34;
  localparam int DIST_W    = 35;
  localparam int CNT_W     = 9;
  localparam int DIMS_W    = 4;

  // All ones marks an entry without a neighbor.
  localparam logic [DIST_W-1:0] DIST_NONE = '1;

  // Input actions and result kinds.
  localparam logic ACT_PUSH    = 1'b0;
  localparam logic ACT_READ    = 1'b1;
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_DIMS = 1'b0;
  localparam logic CFG_CAP  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDWAIT,
    S_SCAN,
    S_DRAIN,
    S_UPD,
    S_INS,
    S_EMIT
  } state_t;

  // Control of one component entering the distance unit.
  typedef struct packed {
    logic             clr;
    logic             vld;
    logic             incl;
    logic [DIM_W-1:0] idx;
  } nnsr_dctl_t;

  // Difference produced by the distance unit.
  typedef struct packed {
    logic                    vld;
    logic [DIM_W-1:0]        idx;
    logic signed [DIF_W-1:0] dif;
  } nnsr_dif_t;

endpackage

[rtl/nnsr_in_if.sv]
// Input channel interface of the sample ring.
interface nnsr_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic signed [15:0] value;
  logic        last_component;
  logic [7:0]  entry_index;
  logic [2:0]  component_index;

  modport source (output valid, action, value, last_component, entry_index,
                  component_index, input ready);
  modport sink (input valid, action, value, last_component, entry_index,
                component_index, output ready);
endinterface

[rtl/nnsr_out_if.sv]
// Result channel interface of the sample ring.
interface nnsr_out_if;
  logic        valid;
  logic        ready;
  logic        reply_kind;
  logic signed [15:0] sample_component;
  logic signed [16:0] diff_component;
  logic [34:0] squared_distance;
  logic [7:0]  slot;
  logic [8:0]  sample_count;
  logic        last_result;

  modport source (output valid, reply_kind, sample_component, diff_component,
                  squared_distance, slot, sample_count, last_result, input ready);
  modport sink (input valid, reply_kind, sample_component, diff_component,
                squared_distance, slot, sample_count, last_result, output ready);
endinterface

[rtl/nnsr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module nnsr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/nnsr_dist.sv]
// Distance unit: difference, square and accumulate, one component a cycle.
module nnsr_dist (
  input  logic                              clk,
  input  logic                              rst_n,
  input  nnsr_pkg::nnsr_dctl_t              ctl,
  input  logic signed [nnsr_pkg::VAL_W-1:0] a_i,
  input  logic signed [nnsr_pkg::VAL_W-1:0] b_i,
  output nnsr_pkg::nnsr_dif_t               dif_o,
  output logic [nnsr_pkg::DIST_W-1:0]       sum_o,
  output logic                              busy_o
);
  import nnsr_pkg::*;

  logic                    v1_r, incl1_r, v2_r;
  logic [DIM_W-1:0]        idx1_r;
  logic signed [DIF_W-1:0] dif1_r;
  logic [SQ_W-1:0]         sq_r;
  logic [DIST_W-1:0]       acc_r;
  logic signed [SQ_W-1:0]  prod;

  // Valid flags of the two pipeline stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctl.vld;
      v2_r <= v1_r && incl1_r;
    end
  end

  // Stage one: difference of incoming and stored component.
  always_ff @(posedge clk) begin
    incl1_r <= ctl.incl;
    idx1_r  <= ctl.idx;
    dif1_r  <= DIF_W'(a_i) - DIF_W'(b_i);
  end

  // Stage two: square of the difference, never negative.
  assign prod = dif1_r * dif1_r;
  always_ff @(posedge clk) begin
    sq_r <= prod[SQ_W-1:0];
  end

  // Stage three: accumulate. Seven squares of 17-bit differences stay
  // below the saturation level, so the sum cannot overflow.
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + DIST_W'(sq_r);
    end
  end

  assign dif_o  = '{vld: v1_r, idx: idx1_r, dif: dif1_r};
  assign sum_o  = acc_r;
  assign busy_o = v1_r || v2_r;

endmodule

[rtl/nearest_neighbor_sample_ring.sv]
// Top level of the nearest-neighbor sample ring: sequencer, stores and I/O.
// A component push is taken in S_IDLE; a read passes through S_RDWAIT to its reply,
// which waits there while the result register is full. Completing a sample scans
// every valid entry, rewrites an entry whose neighbor changes, then inserts the sample and
// reports one result per component in use; the sample memory read port sets the pace.
// Reset (synchronous, rst_n low) empties the ring; stores are not cleared.
module nearest_neighbor_sample_ring (
  input  logic                         clk,
  input  logic                         rst_n,
  nnsr_in_if.sink                      in_ch,
  nnsr_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [nnsr_pkg::CNT_W-1:0]   cfg_wdata
);
  import nnsr_pkg::*;

  state_t                  state_r, state_nxt;
  logic [ENT_W-1:0]        i_r, i_nxt;
  logic [DIM_W-1:0]        j_r, j_nxt;
  logic [DIM_W:0]          comp_cnt_r, comp_cnt_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [ENT_W-1:0]        slot_r, slot_nxt;
  logic [ENT_W-1:0]        eslot_r, eslot_nxt;
  logic [ENT_W-1:0]        rd_ent_r, rd_ent_nxt;
  logic [DIMS_W-1:0]       dims_r;
  logic [CNT_W-1:0]        cap_r;
  logic signed [VAL_W-1:0] inc_r   [MAX_DIM];
  logic signed [DIF_W-1:0] dvec_r  [MAX_DIM];
  logic signed [DIF_W-1:0] bdiff_r [MAX_DIM];
  logic [DIST_W-1:0]       bdist_r;
  nnsr_dctl_t              ctl_r, ctl_nxt;

  logic                    smp_we, smp_re, dif_we, dif_re, dist_we, dist_re;
  logic [SMP_AW-1:0]       smp_waddr, smp_raddr, dif_waddr, dif_raddr;
  logic [ENT_W-1:0]        dist_waddr, dist_raddr;
  logic [VAL_W-1:0]        smp_wdata, smp_rdata;
  logic [DIF_W-1:0]        dif_wdata, dif_rdata;
  logic [DIST_W-1:0]       dist_wdata, dist_rdata;

  nnsr_dif_t               dif_o;
  logic [DIST_W-1:0]       sum;
  logic                    busy;

  logic [DIMS_W-1:0]       dims_eff;
  logic [DIM_W-1:0]        d_last;
  logic [CNT_W-1:0]        cap_eff;
  logic                    in_acc, out_free, out_load;
  logic                    commit_start, commit_end, scan_done, best_upd;
  logic                    last_entry;

  logic                    out_vld_r;
  logic                    out_kind_r, out_kind_nxt;
  logic signed [VAL_W-1:0] out_smp_r, out_smp_nxt;
  logic signed [DIF_W-1:0] out_dif_r, out_dif_nxt;
  logic [DIST_W-1:0]       out_dist_r, out_dist_nxt;
  logic [ENT_W-1:0]        out_slot_r, out_slot_nxt;
  logic [CNT_W-1:0]        out_cnt_r, out_cnt_nxt;
  logic                    out_last_r, out_last_nxt;

  // Configuration registers, clamped where used.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= DIMS_W'(2);
      cap_r  <= CNT_W'(DEPTH);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIMS: dims_r <= cfg_wdata[DIMS_W-1:0];
        CFG_CAP:  cap_r  <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  assign dims_eff = (dims_r < DIMS_W'(2)) ? DIMS_W'(2) :
                    (dims_r > DIMS_W'(MAX_DIM)) ? DIMS_W'(MAX_DIM) : dims_r;
  assign d_last   = DIM_W'(dims_eff - DIMS_W'(1));
  assign cap_eff  = (cap_r == '0) ? CNT_W'(1) :
                    (cap_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_r;

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign out_free   = !out_vld_r || out_ch.ready;
  assign last_entry = (CNT_W'(i_r) + CNT_W'(1)) >= cnt_r;
  assign scan_done  = (state_r == S_DRAIN) && !ctl_r.vld && !busy;
  assign best_upd   = scan_done && (sum < bdist_r);

  // Sequencer: next state, counters, memory accesses and result loading.
  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    comp_cnt_nxt = comp_cnt_r;
    cnt_nxt      = cnt_r;
    slot_nxt     = slot_r;
    eslot_nxt    = eslot_r;
    rd_ent_nxt   = rd_ent_r;
    ctl_nxt      = '0;
    in_ch.ready  = 1'b0;
    commit_start = 1'b0;
    commit_end   = 1'b0;
    smp_we = 1'b0; smp_re = 1'b0; dif_we = 1'b0; dif_re = 1'b0;
    dist_we = 1'b0; dist_re = 1'b0;
    smp_waddr  = {slot_r, j_r};
    smp_raddr  = {i_r, j_r};
    smp_wdata  = inc_r[j_r];
    dif_waddr  = {slot_r, j_r};
    dif_raddr  = {in_ch.entry_index, in_ch.component_index};
    dif_wdata  = bdiff_r[j_r];
    dist_waddr = slot_r;
    dist_raddr = i_r;
    dist_wdata = bdist_r;
    out_load     = 1'b0;
    out_kind_nxt = KIND_INSERT;
    out_smp_nxt  = '0;
    out_dif_nxt  = bdiff_r[j_r];
    out_dist_nxt = bdist_r;
    out_slot_nxt = eslot_r;
    out_cnt_nxt  = cnt_r;
    out_last_nxt = (j_r == d_last);

    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_acc) begin
          if (in_ch.action == ACT_READ) begin
            smp_re     = 1'b1;
            dif_re     = 1'b1;
            dist_re    = 1'b1;
            smp_raddr  = {in_ch.entry_index, in_ch.component_index};
            dist_raddr = in_ch.entry_index;
            rd_ent_nxt = in_ch.entry_index;
            state_nxt  = S_RDWAIT;
          end else begin
            if (comp_cnt_r < (DIM_W+1)'(MAX_DIM)) begin
              comp_cnt_nxt = comp_cnt_r + (DIM_W+1)'(1);
            end
            if (in_ch.last_component) begin
              commit_start = 1'b1;
              i_nxt        = '0;
              j_nxt        = '0;
              state_nxt    = (cnt_r == '0) ? S_INS : S_SCAN;
            end
          end
        end
      end
      S_RDWAIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_kind_nxt = KIND_READ;
          out_smp_nxt  = smp_rdata;
          out_dif_nxt  = dif_rdata;
          out_dist_nxt = dist_rdata;
          out_slot_nxt = rd_ent_r;
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_SCAN: begin
        smp_re  = 1'b1;
        dist_re = (j_r == '0);
        ctl_nxt = '{clr: (j_r == '0), vld: 1'b1, incl: (j_r != d_last), idx: j_r};
        if (j_r == d_last) begin
          j_nxt     = '0;
          state_nxt = S_DRAIN;
        end else begin
          j_nxt = j_r + DIM_W'(1);
        end
      end
      S_DRAIN: begin
        if (scan_done) begin
          if (sum < dist_rdata) begin
            state_nxt = S_UPD;
          end else if (last_entry) begin
            state_nxt = S_INS;
          end else begin
            i_nxt     = i_r + ENT_W'(1);
            state_nxt = S_SCAN;
          end
        end
      end
      S_UPD: begin
        dif_we     = 1'b1;
        dif_waddr  = {i_r, j_r};
        dif_wdata  = dvec_r[j_r];
        dist_we    = (j_r == '0);
        dist_waddr = i_r;
        dist_wdata = sum;
        if (j_r == d_last) begin
          j_nxt = '0;
          if (last_entry) begin
            state_nxt = S_INS;
          end else begin
            i_nxt     = i_r + ENT_W'(1);
            state_nxt = S_SCAN;
          end
        end else begin
          j_nxt = j_r + DIM_W'(1);
        end
      end
      S_INS: begin
        smp_we  = 1'b1;
        dif_we  = 1'b1;
        dist_we = (j_r == '0);
        if (j_r == d_last) begin
          commit_end   = 1'b1;
          j_nxt        = '0;
          comp_cnt_nxt = '0;
          eslot_nxt    = slot_r;
          if (cnt_r < cap_eff) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          slot_nxt  = ((CNT_W'(slot_r) + CNT_W'(1)) >= cap_eff) ? '0 :
                      slot_r + ENT_W'(1);
          state_nxt = S_EMIT;
        end else begin
          j_nxt = j_r + DIM_W'(1);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (j_r == d_last) begin
            j_nxt     = '0;
            state_nxt = S_IDLE;
          end else begin
            j_nxt = j_r + DIM_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      i_r        <= '0;
      j_r        <= '0;
      comp_cnt_r <= '0;
      cnt_r      <= '0;
      slot_r     <= '0;
      ctl_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      comp_cnt_r <= comp_cnt_nxt;
      cnt_r      <= cnt_nxt;
      slot_r     <= slot_nxt;
      ctl_r      <= ctl_nxt;
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Result register and held indexes.
  always_ff @(posedge clk) begin
    eslot_r  <= eslot_nxt;
    rd_ent_r <= rd_ent_nxt;
    if (out_load) begin
      out_kind_r <= out_kind_nxt;
      out_smp_r  <= out_smp_nxt;
      out_dif_r  <= out_dif_nxt;
      out_dist_r <= out_dist_nxt;
      out_slot_r <= out_slot_nxt;
      out_cnt_r  <= out_cnt_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  // Incoming sample: latched per push, zeroed once committed.
  always_ff @(posedge clk) begin
    if (!rst_n || commit_end) begin
      for (int n = 0; n < MAX_DIM; n++) begin
        inc_r[n] <= '0;
      end
    end else if (in_acc && in_ch.action == ACT_PUSH
                 && comp_cnt_r < (DIM_W+1)'(MAX_DIM)) begin
      inc_r[comp_cnt_r[DIM_W-1:0]] <= in_ch.value;
    end
  end

  // Best neighbor of the new sample; a strictly smaller distance wins.
  always_ff @(posedge clk) begin
    if (!rst_n || commit_start) begin
      bdist_r <= DIST_NONE;
      for (int n = 0; n < MAX_DIM; n++) begin
        bdiff_r[n] <= '0;
      end
    end else if (best_upd) begin
      bdist_r <= sum;
      for (int n = 0; n < MAX_DIM; n++) begin
        bdiff_r[n] <= -dvec_r[n];
      end
    end
  end

  // Difference vector of the entry under scan.
  always_ff @(posedge clk) begin
    if (dif_o.vld) begin
      dvec_r[dif_o.idx] <= dif_o.dif;
    end
  end

  nnsr_dist u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl_r),
    .a_i    (inc_r[ctl_r.idx]),
    .b_i    (smp_rdata),
    .dif_o  (dif_o),
    .sum_o  (sum),
    .busy_o (busy)
  );

  nnsr_ram #(.WIDTH(VAL_W), .DEPTH(SMP_DEPTH)) u_smp_ram (
    .clk(clk), .we(smp_we), .waddr(smp_waddr), .wdata(smp_wdata),
    .re(smp_re), .raddr(smp_raddr), .rdata(smp_rdata)
  );

  nnsr_ram #(.WIDTH(DIF_W), .DEPTH(SMP_DEPTH)) u_dif_ram (
    .clk(clk), .we(dif_we), .waddr(dif_waddr), .wdata(dif_wdata),
    .re(dif_re), .raddr(dif_raddr), .rdata(dif_rdata)
  );

  nnsr_ram #(.WIDTH(DIST_W), .DEPTH(DEPTH)) u_dist_ram (
    .clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
    .re(dist_re), .raddr(dist_raddr), .rdata(dist_rdata)
  );

  assign out_ch.valid            = out_vld_r;
  assign out_ch.reply_kind       = out_kind_r;
  assign out_ch.sample_component = out_smp_r;
  assign out_ch.diff_component   = out_dif_r;
  assign out_ch.squared_distance = out_dist_r;
  assign out_ch.slot             = out_slot_r;
  assign out_ch.sample_count     = out_cnt_r;
  assign out_ch.last_result      = out_last_r;

`ifndef SYNTHESIS
  // The ring never holds more entries than it has.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH)) else $error("sample count beyond depth");

  // An insertion always leaves at least one valid entry.
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    commit_end |=> cnt_r != '0) else $error("empty ring after insertion");

  // The scan never writes the sample store.
  a_scan_nowr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_DRAIN || state_r == S_UPD) |-> !smp_we)
    else $error("sample store written during scan");

  // The last insertion report returns the sequencer to idle.
  a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_load && j_r == d_last) |=> state_r == S_IDLE)
    else $error("report run did not end");
`endif

endmodule

[tb/nearest_neighbor_sample_ring_test.sv]
// Self-checking testbench of the nearest-neighbor sample ring: directed table, then random phases.
module nearest_neighbor_sample_ring_test;
  import nnsr_pkg::*;

  localparam longint DIST_SAT   = longint'(DIST_NONE) - 1;
  localparam int     STALL_MAX  = 30000;
  localparam int     SETTLE     = 60;

  // One input transaction.
  typedef struct {
    logic               action;
    logic signed [15:0] value;
    logic               last;
    logic [7:0]         entry;
    logic [2:0]         comp;
  } ring_txn_t;

  // One result transaction.
  typedef struct {
    logic               kind;
    logic signed [15:0] smp;
    logic signed [16:0] dif;
    logic [34:0]        sq_dist;
    logic [7:0]         slot;
    logic [8:0]         cnt;
    logic               last;
  } ring_res_t;

  // Directed row: a transaction and, where it is obvious, its typed result.
  typedef struct {
    ring_txn_t txn;
    bit        typed;
    ring_res_t res;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_DIMS;
  logic [CNT_W-1:0] cfg_wdata = '0;

  nnsr_in_if  in_ch();
  nnsr_out_if out_ch();

  nearest_neighbor_sample_ring dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Mirror of the ring contents and sequencer state.
  logic signed [15:0] ring_sample [DEPTH][MAX_DIM];
  logic signed [16:0] ring_diff   [DEPTH][MAX_DIM];
  logic [34:0]        ring_dist   [DEPTH];
  bit                 ring_written[DEPTH][MAX_DIM];
  logic signed [15:0] pending_sample[MAX_DIM];
  int unsigned        pending_cnt = 0;
  int unsigned        entries_valid = 0;
  int unsigned        next_slot = 0;
  int unsigned        dims_reg = 2;
  int unsigned        cap_reg = 256;

  ring_res_t  expected_results[$];
  ring_res_t  new_results[$];
  table_row_t directed[$];
  logic signed [15:0] prev_sample[MAX_DIM];

  int errors = 0;
  int n_items = 0, n_samples = 0, n_reads = 0, n_results = 0;
  int sender_idle = 0, recv_stall = 0;
  int quiet_cycles = 0;

  // Commit the pending sample and queue its insertion reports.
  task automatic commit_sample();
    int unsigned d, cap, slot;
    longint dif[MAX_DIM];
    longint bdiff[MAX_DIM];
    longint best, sum, a;
    ring_res_t r;
    d = (dims_reg < 2) ? 2 : (dims_reg > MAX_DIM ? MAX_DIM : dims_reg);
    cap = (cap_reg < 1) ? 1 : (cap_reg > DEPTH ? DEPTH : cap_reg);
    best = longint'(DIST_NONE);
    for (int j = 0; j < MAX_DIM; j++) bdiff[j] = 0;
    for (int i = 0; i < entries_valid; i++) begin
      sum = 0;
      for (int j = 0; j < d; j++) begin
        dif[j] = longint'(pending_sample[j]) - longint'(ring_sample[i][j]);
        if (j + 1 < d) begin
          a = (dif[j] < 0) ? -dif[j] : dif[j];
          sum += a * a;
          if (sum > DIST_SAT) sum = DIST_SAT;
        end
      end
      if (sum < longint'(ring_dist[i])) begin
        for (int j = 0; j < d; j++) ring_diff[i][j] = dif[j];
        ring_dist[i] = sum;
      end
      if (sum < best) begin
        for (int j = 0; j < d; j++) bdiff[j] = -dif[j];
        best = sum;
      end
    end
    slot = next_slot % DEPTH;
    for (int j = 0; j < d; j++) begin
      ring_sample[slot][j] = pending_sample[j];
      ring_diff[slot][j] = bdiff[j];
      ring_written[slot][j] = 1'b1;
    end
    ring_dist[slot] = best;
    if (entries_valid < cap) entries_valid++;
    next_slot = slot + 1;
    if (next_slot >= cap) next_slot = 0;
    for (int j = 0; j < MAX_DIM; j++) pending_sample[j] = '0;
    pending_cnt = 0;
    for (int k = 0; k < d; k++) begin
      r.kind = KIND_INSERT; r.smp = '0; r.dif = bdiff[k]; r.sq_dist = best;
      r.slot = slot; r.cnt = entries_valid; r.last = (k + 1 == d);
      new_results.push_back(r);
    end
  endtask

  // Update the mirror with one accepted transaction; results go to new_results.
  task automatic predict_ring(input ring_txn_t t);
    ring_res_t r;
    if (t.action == ACT_READ) begin
      r.kind = KIND_READ; r.smp = ring_sample[t.entry][t.comp];
      r.dif = ring_diff[t.entry][t.comp]; r.sq_dist = ring_dist[t.entry];
      r.slot = t.entry; r.cnt = entries_valid; r.last = 1'b1;
      new_results.push_back(r);
      n_reads++;
    end else begin
      if (pending_cnt < MAX_DIM) begin
        pending_sample[pending_cnt] = t.value;
        pending_cnt++;
      end
      if (t.last) begin
        commit_sample();
        n_samples++;
      end
    end
  endtask

  // Present one transaction on the input channel; the caller sits at a falling edge.
  task automatic send_txn(input ring_txn_t t, input bit typed, input ring_res_t res);
    while ($urandom_range(99) < sender_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.action = t.action;
    in_ch.value = t.value;
    in_ch.last_component = t.last;
    in_ch.entry_index = t.entry;
    in_ch.component_index = t.comp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    new_results.delete();
    predict_ring(t);
    foreach (new_results[k]) begin
      if (typed) begin
        new_results[k].kind = res.kind; new_results[k].smp = res.smp;
        new_results[k].dif = res.dif; new_results[k].sq_dist = res.sq_dist;
        new_results[k].slot = res.slot; new_results[k].cnt = res.cnt;
      end
      expected_results.push_back(new_results[k]);
    end
    n_items++;
    @(negedge clk);
  endtask

  // Wait until every expected result has arrived, plus the block's settling time.
  task automatic drain_ring();
    in_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Write one configuration register while the block is idle.
  task automatic write_reg(input logic idx, input int unsigned val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_DIMS) dims_reg = val & 4'hF;
    else cap_reg = val & 9'h1FF;
  endtask

  // Build a directed row.
  task automatic add_row(input logic act, input int val, input logic lst, input int ent,
                         input int cmp, input bit typed, input ring_res_t res);
    table_row_t row;
    row.txn.action = act; row.txn.value = val; row.txn.last = lst;
    row.txn.entry = ent; row.txn.comp = cmp; row.typed = typed; row.res = res;
    directed.push_back(row);
  endtask

  // Pick a component value: extremes, small values for ties, full range or the previous one.
  function automatic logic signed [15:0] pick_value(input int j);
    case ($urandom_range(3))
      0: pick_value = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      1: pick_value = $signed($urandom_range(4)) - 2;
      2: pick_value = $urandom();
      default: pick_value = prev_sample[j];
    endcase
  endfunction

  // Random traffic of one phase: mostly well-formed samples, some short or long, some reads.
  task automatic run_random(input int n_target, input bit pause_midway);
    int start, d, len, e, c, tries;
    ring_txn_t t;
    ring_res_t none;
    bit paused;
    none = '{default: '0};
    start = n_items;
    paused = 0;
    d = (dims_reg < 2) ? 2 : (dims_reg > MAX_DIM ? MAX_DIM : dims_reg);
    while (n_items - start < n_target) begin
      if (pause_midway && !paused && n_items - start > n_target / 2) begin
        drain_ring();
        paused = 1;
      end
      if ($urandom_range(99) < 15) begin
        e = $urandom_range(255); c = $urandom_range(7); tries = 0;
        while (!ring_written[e][c] && tries < 40) begin
          e = $urandom_range(255); c = $urandom_range(7); tries++;
        end
        if (!ring_written[e][c]) begin
          e = 0; c = 0;
        end
        t.action = ACT_READ; t.value = $urandom(); t.last = $urandom_range(1);
        t.entry = e; t.comp = c;
        send_txn(t, 0, none);
      end else begin
        case ($urandom_range(9))
          0: len = $urandom_range(1, d - 1);
          1: len = $urandom_range(d + 1, 10);
          default: len = d;
        endcase
        for (int j = 0; j < len; j++) begin
          t.action = ACT_PUSH; t.value = pick_value(j % MAX_DIM);
          t.last = (j + 1 == len); t.entry = $urandom(); t.comp = $urandom();
          if (j < MAX_DIM) prev_sample[j] = t.value;
          send_txn(t, 0, none);
        end
      end
    end
  endtask

  // Receiver back-pressure.
  always @(negedge clk) out_ch.ready = ($urandom_range(99) >= recv_stall);

  // Result checker: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    ring_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result kind=%0d slot=%0d", $time, out_ch.reply_kind,
                 out_ch.slot);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_ch.reply_kind !== e.kind || out_ch.sample_component !== e.smp ||
            out_ch.diff_component !== e.dif || out_ch.squared_distance !== e.sq_dist ||
            out_ch.slot !== e.slot || out_ch.sample_count !== e.cnt ||
            out_ch.last_result !== e.last) begin
          $display("%0t: expected kind=%0d smp=%0d dif=%0d dist=%0d slot=%0d cnt=%0d last=%0d",
                   $time, e.kind, e.smp, e.dif, e.sq_dist, e.slot, e.cnt, e.last);
          $display("%0t: actual   kind=%0d smp=%0d dif=%0d dist=%0d slot=%0d cnt=%0d last=%0d",
                   $time, out_ch.reply_kind, out_ch.sample_component, out_ch.diff_component,
                   out_ch.squared_distance, out_ch.slot, out_ch.sample_count,
                   out_ch.last_result);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    ring_res_t typed_res;
    ring_res_t none;
    none = '{default: '0};
    in_ch.valid = 1'b0; in_ch.action = ACT_PUSH; in_ch.value = '0;
    in_ch.last_component = 1'b0; in_ch.entry_index = '0; in_ch.component_index = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < DEPTH; i++)
      for (int j = 0; j < MAX_DIM; j++) ring_written[i][j] = 1'b0;
    for (int j = 0; j < MAX_DIM; j++) begin
      pending_sample[j] = '0;
      prev_sample[j] = '0;
    end

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Out-of-range register values saturate to eight components and a full ring.
    write_reg(CFG_DIMS, 15);
    write_reg(CFG_CAP, 511);

    // First sample after reset: all components at the negative extreme, no neighbor yet.
    typed_res = '{kind: KIND_INSERT, smp: 0, dif: 0, sq_dist: DIST_NONE, slot: 0, cnt: 1,
                  last: 0};
    for (int j = 0; j < 7; j++) add_row(ACT_PUSH, -32768, 0, 255, 7, 0, none);
    add_row(ACT_PUSH, -32768, 1, 128, 4, 1, typed_res);
    typed_res = '{kind: KIND_READ, smp: -32768, dif: 0, sq_dist: DIST_NONE, slot: 0, cnt: 1,
                  last: 1};
    add_row(ACT_READ, 0, 0, 0, 0, 1, typed_res);
    // Second sample at the positive extreme: largest distance without saturation.
    for (int j = 0; j < 8; j++) add_row(ACT_PUSH, 32767, j == 7, 0, 0, 0, none);
    add_row(ACT_READ, 0, 1, 0, 7, 0, none);
    add_row(ACT_READ, 0, 0, 1, 3, 0, none);
    // Short sample: missing components count as zero.
    for (int j = 0; j < 3; j++) add_row(ACT_PUSH, j - 1, j == 2, 85, 2, 0, none);
    // Overlong sample: components past the eighth are ignored.
    for (int j = 0; j < 10; j++) add_row(ACT_PUSH, 1000 * j - 4000, j == 9, 170, 5, 0, none);
    add_row(ACT_READ, 0, 0, 2, 6, 0, none);
    foreach (directed[i]) send_txn(directed[i].txn, directed[i].typed, directed[i].res);
    drain_ring();

    // Random phases; the component count and the capacity only go down, so no stale
    // component is compared and every counted entry has been written.
    write_reg(CFG_DIMS, 8);  write_reg(CFG_CAP, 256);
    sender_idle = 0;  recv_stall = 0;
    run_random(50, 0);
    drain_ring();
    write_reg(CFG_DIMS, 5);  write_reg(CFG_CAP, 9);
    sender_idle = 63; recv_stall = 0;
    run_random(50, 0);
    drain_ring();
    write_reg(CFG_DIMS, 4);  write_reg(CFG_CAP, 6);
    sender_idle = 0;  recv_stall = 63;
    run_random(50, 0);
    drain_ring();
    write_reg(CFG_DIMS, 3);  write_reg(CFG_CAP, 1);
    sender_idle = 29; recv_stall = 29;
    run_random(50, 0);
    drain_ring();
    write_reg(CFG_DIMS, 0);  write_reg(CFG_CAP, 0);
    sender_idle = 0;  recv_stall = 0;
    run_random(55, 1);
    drain_ring();

    $display("Run covered %0d items: %0d samples committed, %0d reads, %0d results checked.",
             n_items, n_samples, n_reads, n_results);
    $display("Settings ran from eight components and a full ring down to two and one entry.");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
